// ----- design/bvd_pkg.sv -----
// ---------------------------------------------------------------------------
// bvd_pkg: shared types and constants of the batch vector distance engine
// Widths, metric and kind codes, controller states, datapath commands and the
// fixed-point constants of the reciprocal square root used by cosine mode.
// ---------------------------------------------------------------------------
package bvd_pkg;

  // Vector geometry and field widths.
  localparam int MAX_DIM      = 1024;
  localparam int ELEMENT_BITS = 16;
  localparam int POS_W        = $clog2(MAX_DIM);
  localparam int LEN_W        = 11;
  localparam int METRIC_W     = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 11;
  localparam int DIST_W       = 43;

  // Accumulator and product widths.
  localparam int ACC_W   = 44;
  localparam int PROD_W  = 2 * (ELEMENT_BITS + 1);
  localparam int NPROD_W = 2 * ELEMENT_BITS;

  // Cosine path widths.
  localparam int EH_W   = 5;
  localparam int S_W    = 6;
  localparam int U_W    = 32;
  localparam int Y0_W   = 30;
  localparam int Y1_W   = 31;
  localparam int MT_W   = 62;
  localparam int AL_W   = 24;
  localparam int AH_W   = ACC_W - AL_W;
  localparam int PLO_W  = AL_W + Y1_W;
  localparam int PHI_W  = AH_W + Y1_W;
  localparam int PSUM_W = ACC_W + Y1_W + 1;
  localparam int Q_W    = 45;
  localparam int CD_W   = Q_W + 2;

  // Metric codes; any other code behaves as squared L2.
  localparam logic [METRIC_W-1:0] METRIC_L2  = 2'd0;
  localparam logic [METRIC_W-1:0] METRIC_DOT = 2'd1;
  localparam logic [METRIC_W-1:0] METRIC_COS = 2'd2;

  // Input item kinds.
  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_TARGET = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b1;

  localparam logic [METRIC_W-1:0] METRIC_RESET = METRIC_L2;
  localparam logic [LEN_W-1:0]    LEN_RESET    = LEN_W'(MAX_DIM);
  localparam logic [LEN_W-1:0]    LEN_MAX      = LEN_W'(MAX_DIM);

  // Result range, Q.30.
  localparam logic signed [DIST_W-1:0] ONE_Q30  = DIST_W'(64'd1 << 30);
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  // Reciprocal square root seeds (Q.30) and their squares, shifted back to Q.30.
  localparam logic [Y0_W-1:0] SEED_LOW    = 30'd889516852;
  localparam logic [Y0_W-1:0] SEED_HIGH   = 30'd628983398;
  localparam logic [63:0]     T_LOW_FULL  = (64'(SEED_LOW) * 64'(SEED_LOW)) >> 30;
  localparam logic [63:0]     T_HIGH_FULL = (64'(SEED_HIGH) * 64'(SEED_HIGH)) >> 30;
  localparam logic [Y0_W-1:0] T_LOW       = T_LOW_FULL[Y0_W-1:0];
  localparam logic [Y0_W-1:0] T_HIGH      = T_HIGH_FULL[Y0_W-1:0];
  localparam logic [U_W-1:0]  THREE_Q30   = 32'hC000_0000;

  localparam logic [EH_W-1:0] EH_START = 5'd15;
  localparam logic [S_W-1:0]  S_BASE   = 6'd15;
  localparam logic [Q_W-1:0]  Q_CAP    = {1'b1, {(Q_W-1){1'b0}}};

  // Controller states.
  typedef enum logic [3:0] {
    ST_RUN,
    ST_WAIT,
    ST_SELECT,
    ST_NORM,
    ST_U,
    ST_Y1,
    ST_LO,
    ST_HI,
    ST_SUM,
    ST_SHIFT,
    ST_DIST,
    ST_EMIT
  } state_t;

  // Finalize operations issued to the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SELECT,
    OP_NORM,
    OP_U,
    OP_Y1,
    OP_LO,
    OP_HI,
    OP_SUM,
    OP_SHIFT,
    OP_DIST
  } op_t;

  typedef struct packed {
    logic                accept;
    logic [POS_W-1:0]    pos;
    logic                last;
    logic [METRIC_W-1:0] metric;
    op_t                 op;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sums_valid;
    logic fin_cosine;
    logic norm_zero;
    logic norm_done;
  } dp_status_t;

endpackage

// ----- design/bvd_if.sv -----
// ---------------------------------------------------------------------------
// bvd_if: stream channels of the batch vector distance engine
// Valid/ready channels for element transactions and for result transactions.
// ---------------------------------------------------------------------------
interface bvd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic signed [bvd_pkg::ELEMENT_BITS-1:0] element;
  logic                                   end_of_batch;

  modport source (output valid, output kind, output element, output end_of_batch,
                  input ready);
  modport sink (input valid, input kind, input element, input end_of_batch,
                output ready);
endinterface

interface bvd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bvd_pkg::DIST_W-1:0] distance;
  logic                              zero_norm;
  logic                              last_in_batch;

  modport source (output valid, output distance, output zero_norm,
                  output last_in_batch, input ready);
  modport sink (input valid, input distance, input zero_norm,
                input last_in_batch, output ready);
endinterface

// ----- design/bvd_ctrl.sv -----
// ---------------------------------------------------------------------------
// bvd_ctrl: controller of the batch vector distance engine
// Holds the configuration registers and the element position, accepts input
// transactions, sequences the finalize steps and owns the result valid flag.
// ---------------------------------------------------------------------------
module bvd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_kind,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          cfg_we,
  input  logic [bvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bvd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bvd_pkg::dp_cmd_t              cmd,
  input  bvd_pkg::dp_status_t           status
);
  import bvd_pkg::*;

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r;
  logic [METRIC_W-1:0] metric_r;
  logic [LEN_W-1:0]    len_r;
  logic                out_valid_r;

  logic [LEN_W-1:0]    len_eff;
  logic [LEN_W-1:0]    pos_inc;
  logic                last;
  logic                accept;
  logic                out_load;
  op_t                 op;

  // Effective vector length: zero acts as one, long values clip to the store.
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_r;
    end
  end

  assign pos_inc  = LEN_W'(pos_r) + LEN_W'(1);
  assign last     = (pos_inc >= len_eff);
  assign in_ready = (state_r == ST_RUN);
  assign accept   = in_valid && in_ready;

  // Configuration registers, written at any time through the plain port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= METRIC_RESET;
      len_r    <= LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_METRIC: metric_r <= cfg_wdata[METRIC_W-1:0];
        CFG_LENGTH: len_r    <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Element position shared by query loads and target elements.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= last ? '0 : pos_inc[POS_W-1:0];
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath operation.
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    out_load  = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (accept && in_kind == KIND_TARGET && last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (status.sums_valid) begin
          state_nxt = ST_SELECT;
        end
      end
      ST_SELECT: begin
        op        = OP_SELECT;
        state_nxt = (status.fin_cosine && !status.norm_zero) ? ST_NORM : ST_EMIT;
      end
      ST_NORM: begin
        op = OP_NORM;
        if (status.norm_done) begin
          state_nxt = ST_U;
        end
      end
      ST_U: begin
        op        = OP_U;
        state_nxt = ST_Y1;
      end
      ST_Y1: begin
        op        = OP_Y1;
        state_nxt = ST_LO;
      end
      ST_LO: begin
        op        = OP_LO;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        op        = OP_HI;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        op        = OP_SUM;
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        op        = OP_SHIFT;
        state_nxt = ST_DIST;
      end
      ST_DIST: begin
        op        = OP_DIST;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_load = !out_valid_r || out_ready;
        if (out_load) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // Result valid flag in front of the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    cmd.accept   = accept;
    cmd.pos      = pos_r;
    cmd.last     = last;
    cmd.metric   = metric_r;
    cmd.op       = op;
    cmd.out_load = out_load;
  end

endmodule

// ----- design/bvd_dp.sv -----
// ---------------------------------------------------------------------------
// bvd_dp: datapath of the batch vector distance engine
// Query store, a two-stage multiply-accumulate pipeline, the finalize unit
// with the normalizer and Newton step for cosine, and the result register.
// ---------------------------------------------------------------------------
module bvd_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bvd_pkg::dp_cmd_t                       cmd,
  output bvd_pkg::dp_status_t                    status,
  input  logic                                   in_kind,
  input  logic signed [bvd_pkg::ELEMENT_BITS-1:0] in_element,
  input  logic                                   in_end_of_batch,
  output logic signed [bvd_pkg::DIST_W-1:0]       out_distance,
  output logic                                   out_zero_norm,
  output logic                                   out_last_in_batch
);
  import bvd_pkg::*;

  // Query store, single port, registered read.
  logic signed [ELEMENT_BITS-1:0] query_mem [MAX_DIM];

  // Stage 1: query and target operands.
  logic signed [ELEMENT_BITS-1:0] q_s1_r, t_s1_r;
  logic                           v_s1_r, last_s1_r, eob_s1_r;
  logic [METRIC_W-1:0]            metric_s1_r;

  // Stage 2: products.
  logic signed [PROD_W-1:0]       p_main_s2_r;
  logic [NPROD_W-1:0]             p_norm_s2_r;
  logic                           v_s2_r, last_s2_r, eob_s2_r;
  logic [METRIC_W-1:0]            metric_s2_r;

  // Accumulators and final sums.
  logic signed [ACC_W-1:0]        acc_main_r, acc_norm_r;
  logic signed [ACC_W-1:0]        fin_d_r;
  logic [ACC_W-1:0]               fin_n_r;
  logic [METRIC_W-1:0]            fin_metric_r;
  logic                           fin_eob_r;

  // Finalize registers.
  logic [ACC_W-1:0]               a_r, m_r;
  logic [EH_W-1:0]                eh_r;
  logic [U_W-1:0]                 u_r;
  logic [Y1_W-1:0]                y1_r;
  logic [PLO_W-1:0]               plo_r;
  logic [PHI_W-1:0]               phi_r;
  logic [PSUM_W-1:0]              psum_r;
  logic [Q_W-1:0]                 q_r;
  logic signed [DIST_W-1:0]       res_r;
  logic                           zn_r;

  // Output register.
  logic signed [DIST_W-1:0]       out_dist_r;
  logic                           out_zn_r, out_eob_r;

  // Combinational helpers.
  logic signed [ELEMENT_BITS:0]   q_ext, t_ext, diff, op_a, op_b;
  logic                           l2_s1;
  logic signed [PROD_W-1:0]       prod_main;
  logic signed [NPROD_W-1:0]      prod_norm;
  logic signed [ACC_W-1:0]        sum_main, sum_norm;
  logic                           sums_valid;
  logic                           big_m, small_m;
  logic [Y0_W-1:0]                y0, t_sel;
  logic [MT_W-1:0]                mt_prod, ny_prod;
  logic [S_W-1:0]                 s_val;
  logic [PSUM_W-1:0]              shifted;
  logic signed [Q_W:0]            q_ext_s, sq;
  logic signed [CD_W-1:0]         cdist;
  logic signed [DIST_W-1:0]       simple_res, cos_res;

  // Query write on a load, query read for every accepted element.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_kind == KIND_QUERY) begin
        query_mem[cmd.pos] <= in_element;
      end
      q_s1_r <= query_mem[cmd.pos];
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_s1_r      <= in_element;
      last_s1_r   <= cmd.last;
      eob_s1_r    <= in_end_of_batch;
      metric_s1_r <= cmd.metric;
    end
  end

  // Stage 1 multiplies: one shared multiplier for the main term, one for the norm.
  always_comb begin
    q_ext     = {q_s1_r[ELEMENT_BITS-1], q_s1_r};
    t_ext     = {t_s1_r[ELEMENT_BITS-1], t_s1_r};
    diff      = q_ext - t_ext;
    l2_s1     = !(metric_s1_r == METRIC_DOT || metric_s1_r == METRIC_COS);
    op_a      = l2_s1 ? diff : q_ext;
    op_b      = l2_s1 ? diff : t_ext;
    prod_main = op_a * op_b;
    prod_norm = t_s1_r * t_s1_r;
  end

  always_ff @(posedge clk) begin
    if (v_s1_r) begin
      p_main_s2_r <= prod_main;
      p_norm_s2_r <= $unsigned(prod_norm);
      last_s2_r   <= last_s1_r;
      eob_s2_r    <= eob_s1_r;
      metric_s2_r <= metric_s1_r;
    end
  end

  // Stage 2 accumulation.
  assign sum_main   = acc_main_r + ACC_W'(p_main_s2_r);
  assign sum_norm   = acc_norm_r + $signed(ACC_W'(p_norm_s2_r));
  assign sums_valid = v_s2_r && last_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r     <= 1'b0;
      v_s2_r     <= 1'b0;
      acc_main_r <= '0;
      acc_norm_r <= '0;
    end else begin
      v_s1_r <= cmd.accept && (in_kind == KIND_TARGET);
      v_s2_r <= v_s1_r;
      if (v_s2_r) begin
        acc_main_r <= last_s2_r ? '0 : sum_main;
        acc_norm_r <= last_s2_r ? '0 : sum_norm;
      end
    end
  end

  // Final sums of a finished target.
  always_ff @(posedge clk) begin
    if (sums_valid) begin
      fin_d_r      <= sum_main;
      fin_n_r      <= $unsigned(sum_norm);
      fin_metric_r <= metric_s2_r;
      fin_eob_r    <= eob_s2_r;
    end
  end

  // Direct results: squared L2 clips above, dot product clips both ways, cosine gives one.
  always_comb begin
    case (fin_metric_r)
      METRIC_DOT: begin
        if (!fin_d_r[ACC_W-1] && fin_d_r[ACC_W-2:DIST_W-1] != '0) begin
          simple_res = DIST_MAX;
        end else if (fin_d_r[ACC_W-1] && fin_d_r[ACC_W-2:DIST_W-1] != '1) begin
          simple_res = DIST_MIN;
        end else begin
          simple_res = fin_d_r[DIST_W-1:0];
        end
      end
      METRIC_COS: begin
        simple_res = ONE_Q30;
      end
      default: begin
        if (fin_d_r[ACC_W-1:DIST_W-1] != '0) begin
          simple_res = DIST_MAX;
        end else begin
          simple_res = fin_d_r[DIST_W-1:0];
        end
      end
    endcase
  end

  // Normalizer flags and seed selection.
  assign big_m   = (m_r[ACC_W-1:32] != '0);
  assign small_m = !big_m && (m_r[31:30] == 2'b00);
  assign y0      = m_r[31] ? SEED_HIGH : SEED_LOW;
  assign t_sel   = m_r[31] ? T_HIGH : T_LOW;
  assign mt_prod = MT_W'(m_r[31:0]) * MT_W'(t_sel);
  assign ny_prod = MT_W'(y0) * MT_W'(THREE_Q30 - u_r);

  // Scaling shift, clip, sign and subtraction from one.
  assign s_val   = S_BASE + S_W'(eh_r);
  assign shifted = psum_r >> s_val;
  assign q_ext_s = $signed({1'b0, q_r});
  assign sq      = fin_d_r[ACC_W-1] ? -q_ext_s : q_ext_s;
  assign cdist   = CD_W'(ONE_Q30) - CD_W'(sq);

  always_comb begin
    if (!cdist[CD_W-1] && cdist[CD_W-2:DIST_W-1] != '0) begin
      cos_res = DIST_MAX;
    end else if (cdist[CD_W-1] && cdist[CD_W-2:DIST_W-1] != '1) begin
      cos_res = DIST_MIN;
    end else begin
      cos_res = cdist[DIST_W-1:0];
    end
  end

  // Finalize steps, one per controller command.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SELECT: begin
        a_r   <= fin_d_r[ACC_W-1] ? $unsigned(-fin_d_r) : $unsigned(fin_d_r);
        m_r   <= fin_n_r;
        eh_r  <= EH_START;
        res_r <= simple_res;
        zn_r  <= (fin_metric_r == METRIC_COS) && (fin_n_r == '0);
      end
      OP_NORM: begin
        if (big_m) begin
          m_r  <= m_r >> 2;
          eh_r <= eh_r + EH_W'(1);
        end else if (small_m) begin
          m_r  <= m_r << 2;
          eh_r <= eh_r - EH_W'(1);
        end
      end
      OP_U: begin
        u_r <= mt_prod[MT_W-1:30];
      end
      OP_Y1: begin
        y1_r <= ny_prod[MT_W-1:31];
      end
      OP_LO: begin
        plo_r <= PLO_W'(a_r[AL_W-1:0]) * PLO_W'(y1_r);
      end
      OP_HI: begin
        phi_r <= PHI_W'(a_r[ACC_W-1:AL_W]) * PHI_W'(y1_r);
      end
      OP_SUM: begin
        psum_r <= PSUM_W'({phi_r, {AL_W{1'b0}}}) + PSUM_W'(plo_r);
      end
      OP_SHIFT: begin
        q_r <= (shifted > PSUM_W'(Q_CAP)) ? Q_CAP : shifted[Q_W-1:0];
      end
      OP_DIST: begin
        res_r <= cos_res;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_dist_r <= res_r;
      out_zn_r   <= zn_r;
      out_eob_r  <= fin_eob_r;
    end
  end

  assign out_distance      = out_dist_r;
  assign out_zero_norm     = out_zn_r;
  assign out_last_in_batch = out_eob_r;

  always_comb begin
    status.sums_valid = sums_valid;
    status.fin_cosine = (fin_metric_r == METRIC_COS);
    status.norm_zero  = (fin_n_r == '0);
    status.norm_done  = !big_m && !small_m;
  end

endmodule

// ----- design/batch_vector_distance_top.sv -----
// ---------------------------------------------------------------------------
// batch_vector_distance_top: batch vector distance engine
// Loads a query vector, streams target vectors against it and returns one
// squared L2, dot product or cosine distance per target.
// ---------------------------------------------------------------------------
// Query loads and target elements other than a target's last are taken one
// per cycle; each passes a registered read of the 1024 x 16 single-port query
// store and a two-stage multiply-accumulate pipeline. A target's last element
// holds the input in squared L2 and dot product mode while the pipeline
// drains, the result is picked and the output register is loaded, and in
// cosine mode with a nonzero norm also while the normalizer shifts the norm
// two bits per cycle and the reciprocal square root and scaling take 7 more
// steps on a shared sequence of narrow multiplies. A stalled output adds its
// wait to that last element only. The query store has no reset; every entry
// must be loaded before a target reads it.
module batch_vector_distance_top (
  input  logic                          clk,
  input  logic                          rst_n,
  bvd_in_if.sink                        in_ch,
  bvd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [bvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bvd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bvd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  // Controller.
  bvd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath.
  bvd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_kind           (in_ch.kind),
    .in_element        (in_ch.element),
    .in_end_of_batch   (in_ch.end_of_batch),
    .out_distance      (out_ch.distance),
    .out_zero_norm     (out_ch.zero_norm),
    .out_last_in_batch (out_ch.last_in_batch)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

// ----- design/bvd_checker.sv -----
// ---------------------------------------------------------------------------
// bvd_checker: port-level checks of the batch vector distance engine
// Watches the element, result and configuration ports over time.
// ---------------------------------------------------------------------------
module bvd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_kind,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [bvd_pkg::DIST_W-1:0] out_distance,
  input logic                          out_zero_norm,
  input logic                          cfg_we,
  input logic [bvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [bvd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bvd_pkg::*;

  // Tracks whether every vector is one element long.
  logic len_one_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_one_r <= 1'b0;
    end else if (cfg_we && cfg_index == CFG_LENGTH) begin
      len_one_r <= (cfg_wdata <= CFG_DATA_W'(1));
    end
  end

  // A stalled result keeps its transaction unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) &&
    $stable(out_zero_norm))
    else $error("result transaction changed while stalled");

  // A zero-norm cosine result is exactly one.
  a_zero_norm_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_norm |-> out_distance == ONE_Q30)
    else $error("zero-norm result is not one");

  // With one-element vectors every target element ends a vector and stalls input.
  a_len_one_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_TARGET && len_one_r |=> !in_ready)
    else $error("input not held after a finished target");

  // A new result only appears while input transactions are held off.
  a_result_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input was open");

endmodule

bind batch_vector_distance_top bvd_checker u_bvd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_kind       (in_ch.kind),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_distance  (out_ch.distance),
  .out_zero_norm (out_ch.zero_norm),
  .cfg_we        (cfg_we),
  .cfg_index     (cfg_index),
  .cfg_wdata     (cfg_wdata)
);
